// ----- hdl/wide_counter_compare_alarms_assert.svh -----
// Assertion macros for the wide counter compare block.
`ifndef WIDE_COUNTER_COMPARE_ALARMS_ASSERT_SVH
`define WIDE_COUNTER_COMPARE_ALARMS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define WCCA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define WCCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);
`else
`define WCCA_ASSERT_IMPL(label, ante, cons, msg)
`define WCCA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hdl/wcca_pkg.sv -----
// Types and constants for the wide counter compare block.
`default_nettype none
package wcca_pkg;

    localparam int unsigned CHANNELS_DEFAULT   = 2;
    localparam int unsigned COUNT_BITS_DEFAULT = 52;

    localparam int unsigned S_TDATA_BITS = 40;
    localparam int unsigned S_TUSER_BITS = 2;
    localparam int unsigned M_TDATA_BITS = 40;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef logic [3:0] addr_t;

    localparam addr_t ADDR_START    = 4'd0;
    localparam addr_t ADDR_MODE     = 4'd1;
    localparam addr_t ADDR_COUNT_LO = 4'd2;
    localparam addr_t ADDR_COUNT_HI = 4'd3;
    localparam addr_t ADDR_INTEN_SET = 4'd4;
    localparam addr_t ADDR_INTEN_CLR = 4'd5;
    localparam addr_t ADDR_PENDING  = 4'd6;
    localparam addr_t ADDR_CH_BASE  = 4'd7;

    // Register offsets within one channel's four-address window
    localparam logic [1:0] CH_REG_CMP_LO  = 2'd0;
    localparam logic [1:0] CH_REG_CMP_HI  = 2'd1;
    localparam logic [1:0] CH_REG_CMP_EN  = 2'd2;
    localparam logic [1:0] CH_REG_CMP_EVT = 2'd3;

endpackage
`default_nettype wire

// ----- hdl/wide_counter_compare_alarms.sv -----
// Wide microsecond counter with compare channels, streaming bus front end.
// Path from input transfer to result: input register, then result register.
// Throughput: one item per cycle while the result side accepts; the counter add and compare sit in one stage.
// Input is taken while a result waits only if the input register is empty; each stage refills as it drains.
// Reset: aresetn synchronous active low; counter, mode, flags and channel state clear.
// Compare values also reset to zero.
`default_nettype none
`include "wide_counter_compare_alarms_assert.svh"
module wide_counter_compare_alarms #(
    parameter int unsigned CHANNELS   = wcca_pkg::CHANNELS_DEFAULT,
    parameter int unsigned COUNT_BITS = wcca_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // tdata: [3:0] address, [35:4] write_data, [39:36] zero
    input  wire logic [wcca_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    // tuser: [1:0] opcode
    input  wire logic [wcca_pkg::S_TUSER_BITS-1:0] s_axis_tuser,
    // result channel
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: [31:0] read_data, [32] irq, [39:33] zero
    output      logic [wcca_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);
    import wcca_pkg::*;

    localparam int unsigned HIGH_BITS = COUNT_BITS - 32;
    // one past the last channel address
    localparam int unsigned CH_END    = int'(ADDR_CH_BASE) + 4 * CHANNELS;

    // ---------------- input register ----------------
    logic        in_valid_reg;
    opcode_t     in_op_reg;
    addr_t       in_addr_reg;
    logic [31:0] in_data_reg;

    // ---------------- result register ----------------
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic        out_irq_reg;

    // ---------------- peripheral state ----------------
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  enabled_reg, enabled_next;
    logic                  running_reg, running_next;
    logic                  wrap_reg, wrap_next;
    logic [COUNT_BITS-1:0] cmp_val_reg  [CHANNELS];
    logic [COUNT_BITS-1:0] cmp_val_next [CHANNELS];
    logic [CHANNELS-1:0]   cmp_en_reg, cmp_en_next;
    logic [CHANNELS-1:0]   cmp_evt_reg, cmp_evt_next;
    logic [CHANNELS-1:0]   inten_reg, inten_next;

    logic [31:0] rdata_next;
    logic        irq_next;

    // Result stage frees when empty or its transfer completes; the input stage
    // moves into it in the same cycle.
    logic out_free;
    logic stage_advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stage_advance = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_irq_reg, out_rdata_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_op_reg   <= opcode_t'(s_axis_tuser[1:0]);
            in_addr_reg <= s_axis_tdata[3:0];
            in_data_reg <= s_axis_tdata[35:4];
        end
    end

    // ---------------- single-pass item processing ----------------
    always_comb begin
        logic [3:0]  ch_off;
        logic        ch_hit;
        logic        ch_sel;
        logic [63:0] cnt_wide;
        logic [63:0] cmp_wide;
        logic [COUNT_BITS-1:0] cnt_inc;

        cnt_next     = cnt_reg;
        enabled_next = enabled_reg;
        running_next = running_reg;
        wrap_next    = wrap_reg;
        cmp_val_next = cmp_val_reg;
        cmp_en_next  = cmp_en_reg;
        cmp_evt_next = cmp_evt_reg;
        inten_next   = inten_reg;
        rdata_next   = 32'd0;
        ch_sel       = 1'b0;
        cmp_wide     = 64'd0;

        ch_off   = in_addr_reg - ADDR_CH_BASE;
        ch_hit   = (in_addr_reg >= ADDR_CH_BASE) && ({1'b0, in_addr_reg} < 5'(CH_END));
        cnt_wide = 64'(cnt_reg);
        cnt_inc  = cnt_reg + 1'b1;

        unique case (in_op_reg)
            OP_TICK: begin
                if (enabled_reg && running_reg) begin
                    cnt_next = cnt_inc;
                    if (cnt_inc[31:0] == 32'd0) begin
                        wrap_next = 1'b1;
                    end
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (cmp_en_reg[c] && (cmp_val_reg[c] == cnt_inc)) begin
                            cmp_evt_next[c] = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (in_addr_reg) inside
                    ADDR_START: rdata_next = 32'd0;
                    ADDR_MODE:  rdata_next = {31'd0, enabled_reg};
                    ADDR_COUNT_LO: begin
                        rdata_next = cnt_reg[31:0];
                        wrap_next  = 1'b0;
                    end
                    ADDR_COUNT_HI: rdata_next = {wrap_reg, cnt_wide[62:32]};
                    ADDR_INTEN_SET, ADDR_INTEN_CLR: rdata_next = 32'(inten_reg);
                    ADDR_PENDING: rdata_next = 32'(inten_reg & cmp_evt_reg);
                    default: begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            ch_sel   = ch_hit && (ch_off[3:2] == 2'(c));
                            cmp_wide = 64'(cmp_val_reg[c]);
                            if (ch_sel) begin
                                case (ch_off[1:0])
                                    CH_REG_CMP_LO:  rdata_next = cmp_wide[31:0];
                                    CH_REG_CMP_HI:  rdata_next = cmp_wide[63:32];
                                    CH_REG_CMP_EN:  rdata_next = {31'd0, cmp_en_reg[c]};
                                    default:        rdata_next = {31'd0, cmp_evt_reg[c]};
                                endcase
                            end
                        end
                    end
                endcase
            end
            OP_WRITE: begin
                unique case (in_addr_reg)
                    ADDR_START: begin
                        if (in_data_reg[0]) begin
                            running_next = 1'b1;
                        end
                    end
                    ADDR_MODE:      enabled_next = in_data_reg[0];
                    ADDR_INTEN_SET: inten_next = inten_reg | in_data_reg[CHANNELS-1:0];
                    ADDR_INTEN_CLR: inten_next = inten_reg & ~in_data_reg[CHANNELS-1:0];
                    default: begin
                        // count and pending are read-only; unmapped writes drop
                        for (int c = 0; c < CHANNELS; c++) begin
                            ch_sel = ch_hit && (ch_off[3:2] == 2'(c));
                            if (ch_sel) begin
                                case (ch_off[1:0])
                                    CH_REG_CMP_LO:
                                        cmp_val_next[c][31:0] = in_data_reg;
                                    CH_REG_CMP_HI:
                                        cmp_val_next[c][COUNT_BITS-1:32] =
                                            in_data_reg[HIGH_BITS-1:0];
                                    CH_REG_CMP_EN:  cmp_en_next[c]  = in_data_reg[0];
                                    default:        cmp_evt_next[c] = in_data_reg[0];
                                endcase
                            end
                        end
                    end
                endcase
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase

        irq_next = |(cmp_evt_next & inten_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            enabled_reg <= 1'b0;
            running_reg <= 1'b0;
            wrap_reg    <= 1'b0;
            cmp_en_reg  <= '0;
            cmp_evt_reg <= '0;
            inten_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                cmp_val_reg[c] <= '0;
            end
        end else if (stage_advance) begin
            cnt_reg      <= cnt_next;
            enabled_reg  <= enabled_next;
            running_reg  <= running_next;
            wrap_reg     <= wrap_next;
            cmp_val_reg  <= cmp_val_next;
            cmp_en_reg   <= cmp_en_next;
            cmp_evt_reg  <= cmp_evt_next;
            inten_reg    <= inten_next;
        end
    end

    // result register: loads on advance, empties on an m-side transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_advance) begin
            out_rdata_reg <= rdata_next;
            out_irq_reg   <= irq_next;
        end
    end

    // ---------------- assertions ----------------
    `WCCA_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready,
        in_valid_reg && out_valid_reg, "input stalled with a free stage")
    `WCCA_ASSERT_IMPL(a_count_steps_by_one, $past(aresetn),
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == COUNT_BITS'($past(cnt_reg) + 1'b1)),
        "counter moved by other than one")
    `WCCA_ASSERT_IMPL(a_count_needs_run, $past(aresetn) && (cnt_reg != $past(cnt_reg)),
        $past(enabled_reg && running_reg && stage_advance), "counter moved while stopped")
    `WCCA_ASSERT_NEXT(a_running_sticks, running_reg, running_reg,
        "counter run flag cleared without reset")

endmodule
`default_nettype wire
